// File: hw/rtl/jssd_pkg.sv
// Job-shop schedule decoder: shared field types, function codes and limits.
// No dependencies; imported by the interfaces, the decoder unit, the checker and the testbench.
package jssd_pkg;

  localparam int JOB_W  = 6;
  localparam int OP_W   = 5;
  localparam int MACH_W = 5;
  localparam int DUR_W  = 16;
  localparam int SLOT_W = 11;
  localparam int TIME_W = 27;

  typedef logic [1:0]        func_t;
  typedef logic [JOB_W-1:0]  job_t;
  typedef logic [OP_W-1:0]   op_t;
  typedef logic [MACH_W-1:0] mach_t;
  typedef logic [DUR_W-1:0]  dur_t;
  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [TIME_W-1:0] time_t;

  localparam func_t FUNC_LOAD  = 2'd0;
  localparam func_t FUNC_GENE  = 2'd1;
  localparam func_t FUNC_CLEAR = 2'd2;

  localparam time_t TIME_MAX = {TIME_W{1'b1}};
  localparam slot_t SLOT_MAX = {SLOT_W{1'b1}};

  typedef struct packed {
    job_t  res_job;
    op_t   res_op;
    mach_t res_machine;
    slot_t slot;
    time_t begin_time;
    time_t end_time;
    logic  error;
  } res_t;

endpackage

// File: hw/rtl/jssd_if.sv
// Valid/ready channels of the schedule decoder: input items and result items.
// Depends on jssd_pkg for the field types.
interface jssd_in_if;
  import jssd_pkg::*;
  logic  valid;
  logic  ready;
  func_t func;
  job_t  job;
  op_t   op_index;
  mach_t machine;
  dur_t  duration;

  modport source(output valid, output func, output job, output op_index,
                 output machine, output duration, input ready);
  modport sink(input valid, input func, input job, input op_index,
               input machine, input duration, output ready);
endinterface

interface jssd_out_if;
  import jssd_pkg::*;
  logic  valid;
  logic  ready;
  job_t  res_job;
  op_t   res_op;
  mach_t res_machine;
  slot_t slot;
  time_t begin_time;
  time_t end_time;
  logic  error;

  modport source(output valid, output res_job, output res_op, output res_machine,
                 output slot, output begin_time, output end_time, output error,
                 input ready);
  modport sink(input valid, input res_job, input res_op, input res_machine,
               input slot, input begin_time, input end_time, input error,
               output ready);
endinterface

// File: hw/rtl/jssd_route_mem.sv
// Routing table: machine and duration per job and operation, registered read.
// Contents are undefined until loaded. No package dependencies.
module jssd_route_mem #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 21
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_q_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_q_r;

endmodule

// File: hw/rtl/jssd_vmem.sv
// State memory with per-entry valid bits: an invalid entry reads as zero.
// A clear drops all valid bits at once. No package dependencies.
module jssd_vmem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 33
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     clr,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_q_r;
  logic [DEPTH-1:0] vld_r;
  logic             rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (clr) begin
        vld_r <= '0;
      end else if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

// File: hw/rtl/job_shop_schedule_decoder_unit.sv
// Job-shop schedule decoder. Load and clear transactions leave it idle.
// A gene passes from acceptance to its result through three dependent
// registered memory reads (job state, routing table, machine state) followed
// by the max/add/saturate step, which writes back both ready times and loads
// the output register. A gene for an exhausted job returns its error result
// after the job-state read, an out-of-range routed machine after the routing
// read, a job index of MAX_JOBS or more with no read. The output register holds a
// result while the next transaction is accepted; a new result waits only if it is still full.
// Schedule state resets through valid bits, so there is no clearing pass.
module job_shop_schedule_decoder_unit #(
  parameter int MAX_JOBS      = 64,
  parameter int MAX_MACHINES  = 32,
  parameter int MAX_OPS       = 32,
  parameter int DURATION_BITS = 16
) (
  input logic         clk,
  input logic         rst_n,
  jssd_in_if.sink     in_ch,
  jssd_out_if.source  out_ch
);
  import jssd_pkg::*;

  localparam int JAW    = $clog2(MAX_JOBS);
  localparam int MAW    = $clog2(MAX_MACHINES);
  localparam int OPW    = $clog2(MAX_OPS + 1);
  localparam int RDEPTH = MAX_JOBS * MAX_OPS;
  localparam int RAW    = $clog2(RDEPTH);
  localparam int JMW    = OPW + TIME_W;
  localparam int MMW    = SLOT_W + TIME_W;
  localparam int RMW    = MACH_W + DURATION_BITS;
  localparam int SUMW   = ((DURATION_BITS > TIME_W) ? DURATION_BITS : TIME_W) + 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_JOB   = 3'd1;
  localparam logic [2:0] ST_ROUTE = 3'd2;
  localparam logic [2:0] ST_MACH  = 3'd3;
  localparam logic [2:0] ST_ERR   = 3'd4;

  logic [2:0]               state_r, state_nxt;
  job_t                     job_r;
  logic [JAW-1:0]           jaddr_r;
  logic [OPW-1:0]           opn_r;
  time_t                    jrdy_r;
  mach_t                    mach_r;
  logic [DURATION_BITS-1:0] dur_r;
  logic                     out_valid_r, out_valid_nxt;
  res_t                     res_r, res_nxt;

  logic accept, out_free, job_ok, op_ok, is_load, is_gene, is_clear;

  // route memory
  logic               rt_rd_en, rt_wr_en;
  logic [RAW-1:0]     rt_rd_addr, rt_wr_addr;
  logic [RMW-1:0]     rt_rd_data, rt_wr_data;
  // job state memory: {next op, ready time}
  logic               jb_rd_en, jb_wr_en, sched_clr;
  logic [JAW-1:0]     jb_rd_addr;
  logic [JMW-1:0]     jb_rd_data, jb_wr_data;
  // machine state memory: {slot count, ready time}
  logic               mc_rd_en, mc_wr_en;
  logic [MAW-1:0]     mc_rd_addr, mc_wr_addr;
  logic [MMW-1:0]     mc_rd_data, mc_wr_data;

  logic [OPW-1:0]     job_nop;
  logic               exhausted;
  mach_t              rt_mach;
  logic               mach_bad;
  time_t              mrdy, beg_time, fin_time;
  slot_t              mslot, slot_inc;
  logic [SUMW-1:0]    sum;
  logic               fire, emit_err;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign is_load  = in_ch.func == FUNC_LOAD;
  assign is_gene  = in_ch.func == FUNC_GENE;
  assign is_clear = in_ch.func == FUNC_CLEAR;
  assign job_ok   = 32'(in_ch.job) < 32'(MAX_JOBS);
  assign op_ok    = 32'(in_ch.op_index) < 32'(MAX_OPS);

  // nothing is taken while reset is held
  assign in_ch.ready = rst_n && (state_r == ST_IDLE);

  // load path
  assign rt_wr_en   = accept && is_load && job_ok && op_ok;
  assign rt_wr_addr = RAW'(32'(in_ch.job) * 32'(MAX_OPS) + 32'(in_ch.op_index));
  assign rt_wr_data = {in_ch.machine, DURATION_BITS'(in_ch.duration)};
  assign sched_clr  = accept && is_clear;

  // step 1: job state
  assign jb_rd_en   = accept && is_gene && job_ok;
  assign jb_rd_addr = JAW'(in_ch.job);
  assign job_nop    = jb_rd_data[JMW-1:TIME_W];
  assign exhausted  = 32'(job_nop) >= 32'(MAX_OPS);

  // step 2: routing entry
  assign rt_rd_en   = (state_r == ST_JOB) && !exhausted;
  assign rt_rd_addr = RAW'(32'(job_r) * 32'(MAX_OPS) + 32'(job_nop));
  assign rt_mach    = rt_rd_data[RMW-1:DURATION_BITS];
  assign mach_bad   = 32'(rt_mach) >= 32'(MAX_MACHINES);

  // step 3: machine state, then max/add and write-back
  assign mc_rd_en   = (state_r == ST_ROUTE) && !mach_bad;
  assign mc_rd_addr = MAW'(rt_mach);
  assign mrdy       = mc_rd_data[TIME_W-1:0];
  assign mslot      = mc_rd_data[MMW-1:TIME_W];
  assign beg_time   = (mrdy > jrdy_r) ? mrdy : jrdy_r;
  assign sum        = SUMW'(beg_time) + SUMW'(dur_r);
  assign fin_time   = (sum > SUMW'(TIME_MAX)) ? TIME_MAX : sum[TIME_W-1:0];
  assign slot_inc   = (mslot == SLOT_MAX) ? mslot : mslot + 1'b1;

  assign fire       = (state_r == ST_MACH) && out_free;
  assign emit_err   = (state_r == ST_ERR) && out_free;
  assign jb_wr_en   = fire;
  assign jb_wr_data = {opn_r + OPW'(1), fin_time};
  assign mc_wr_en   = fire;
  assign mc_wr_addr = MAW'(mach_r);
  assign mc_wr_data = {slot_inc, fin_time};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && is_gene) begin
          state_nxt = job_ok ? ST_JOB : ST_ERR;
        end
      end
      ST_JOB: begin
        state_nxt = exhausted ? ST_ERR : ST_ROUTE;
      end
      ST_ROUTE: begin
        state_nxt = mach_bad ? ST_ERR : ST_MACH;
      end
      ST_MACH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_ERR: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (fire) begin
      res_nxt.res_job     = job_r;
      res_nxt.res_op      = OP_W'(opn_r);
      res_nxt.res_machine = mach_r;
      res_nxt.slot        = mslot;
      res_nxt.begin_time  = beg_time;
      res_nxt.end_time    = fin_time;
      res_nxt.error       = 1'b0;
      out_valid_nxt       = 1'b1;
    end else if (emit_err) begin
      res_nxt             = '0;
      res_nxt.res_job     = job_r;
      res_nxt.error       = 1'b1;
      out_valid_nxt       = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (accept) begin
      job_r   <= in_ch.job;
      jaddr_r <= JAW'(in_ch.job);
    end
    if (state_r == ST_JOB) begin
      opn_r  <= job_nop;
      jrdy_r <= jb_rd_data[TIME_W-1:0];
    end
    if (state_r == ST_ROUTE) begin
      mach_r <= rt_mach;
      dur_r  <= rt_rd_data[DURATION_BITS-1:0];
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.res_job     = res_r.res_job;
  assign out_ch.res_op      = res_r.res_op;
  assign out_ch.res_machine = res_r.res_machine;
  assign out_ch.slot        = res_r.slot;
  assign out_ch.begin_time  = res_r.begin_time;
  assign out_ch.end_time    = res_r.end_time;
  assign out_ch.error       = res_r.error;

  jssd_route_mem #(.DEPTH(RDEPTH), .WIDTH(RMW)) u_route (
    .clk     (clk),
    .rd_en   (rt_rd_en),
    .rd_addr (rt_rd_addr),
    .rd_data (rt_rd_data),
    .wr_en   (rt_wr_en),
    .wr_addr (rt_wr_addr),
    .wr_data (rt_wr_data)
  );

  jssd_vmem #(.DEPTH(MAX_JOBS), .WIDTH(JMW)) u_job_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (sched_clr),
    .rd_en   (jb_rd_en),
    .rd_addr (jb_rd_addr),
    .rd_data (jb_rd_data),
    .wr_en   (jb_wr_en),
    .wr_addr (jaddr_r),
    .wr_data (jb_wr_data)
  );

  jssd_vmem #(.DEPTH(MAX_MACHINES), .WIDTH(MMW)) u_mach_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (sched_clr),
    .rd_en   (mc_rd_en),
    .rd_addr (mc_rd_addr),
    .rd_data (mc_rd_data),
    .wr_en   (mc_wr_en),
    .wr_addr (mc_wr_addr),
    .wr_data (mc_wr_data)
  );

endmodule

// File: hw/rtl/jssd_chk.sv
// Port-level checks for the schedule decoder, bound to the top level.
// Depends on jssd_pkg and job_shop_schedule_decoder_unit.
module jssd_chk (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input jssd_pkg::func_t in_func,
  input logic            out_valid,
  input logic            out_ready,
  input jssd_pkg::op_t   res_op,
  input jssd_pkg::mach_t res_machine,
  input jssd_pkg::slot_t slot,
  input jssd_pkg::time_t begin_time,
  input jssd_pkg::time_t end_time,
  input logic            error
);
  import jssd_pkg::*;

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(begin_time) && $stable(end_time)
      && $stable(slot) && $stable(error))
    else $error("result changed while stalled");

  // loads and clears produce no result
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_func != FUNC_GENE && !out_valid |=> !out_valid)
    else $error("result without a gene");

  // an accepted gene makes the block busy and drops input ready
  a_gene_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_func == FUNC_GENE |=> !in_ready)
    else $error("accepted during gene processing");

  // error results carry only the job
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && error |-> res_op == '0 && res_machine == '0 && slot == '0
      && begin_time == '0 && end_time == '0)
    else $error("error result with nonzero fields");

  // operations never end before they begin
  a_time_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !error |-> end_time >= begin_time)
    else $error("end time before begin time");

endmodule

bind job_shop_schedule_decoder_unit jssd_chk u_jssd_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .in_func     (in_ch.func),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .res_op      (out_ch.res_op),
  .res_machine (out_ch.res_machine),
  .slot        (out_ch.slot),
  .begin_time  (out_ch.begin_time),
  .end_time    (out_ch.end_time),
  .error       (out_ch.error)
);

// File: tb/tb.sv
`timescale 1ns / 1ps
// Testbench for job_shop_schedule_decoder_unit: corner transactions, job exhaustion and
// randomized routing tables with shuffled chromosomes, checked against a local schedule tracker.
// Depends on jssd_pkg and the jssd_in_if / jssd_out_if channel interfaces.
module tb;
  import jssd_pkg::*;

  localparam int N_JOBS       = 64;
  localparam int N_MACH       = 32;
  localparam int N_OPS        = 32;
  localparam int ROUTE_DEPTH  = N_JOBS * N_OPS;
  localparam func_t FUNC_NOP  = 2'd3;
  localparam int DRAIN_CYCLES = 12;
  localparam int REPORT_LIMIT = 10;

  logic clk;
  logic rst_n;

  jssd_in_if  in_ch();
  jssd_out_if out_ch();

  job_shop_schedule_decoder_unit u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // schedule state, advanced at each accepted transaction
  mach_t route_mach   [ROUTE_DEPTH];
  dur_t  route_dur    [ROUTE_DEPTH];
  bit    route_loaded [ROUTE_DEPTH];
  time_t job_ready    [N_JOBS];
  time_t mach_ready   [N_MACH];
  int    next_op      [N_JOBS];
  slot_t mach_slot    [N_MACH];
  res_t  scheduled_ops[$];

  int send_idle_pct;
  int recv_idle_pct;
  int mismatches;
  int items_sent;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic clear_schedule();
    for (int k = 0; k < N_JOBS; k++) begin
      job_ready[k] = '0;
      next_op[k]   = 0;
    end
    for (int k = 0; k < N_MACH; k++) begin
      mach_ready[k] = '0;
      mach_slot[k]  = '0;
    end
  endtask

  task automatic decode_transaction(func_t f, job_t j, op_t o, mach_t m, dur_t d);
    int idx;
    mach_t mm;
    time_t start;
    logic [TIME_W:0] sum;
    res_t r;
    r = '0;
    r.res_job = j;
    case (f)
      FUNC_LOAD: begin
        if (j < N_JOBS && o < N_OPS) begin
          idx = int'(j) * N_OPS + int'(o);
          route_mach[idx]   = m;
          route_dur[idx]    = d;
          route_loaded[idx] = 1'b1;
        end
      end
      FUNC_CLEAR: clear_schedule();
      FUNC_GENE: begin
        if (j >= N_JOBS || next_op[j] >= N_OPS) begin
          r.error = 1'b1;
          scheduled_ops.push_back(r);
        end else begin
          idx = int'(j) * N_OPS + next_op[j];
          mm  = route_mach[idx];
          if (mm >= N_MACH) begin
            r.error = 1'b1;
            scheduled_ops.push_back(r);
          end else begin
            start = (mach_ready[mm] > job_ready[j]) ? mach_ready[mm] : job_ready[j];
            sum   = {1'b0, start} + route_dur[idx];
            r.res_op      = op_t'(next_op[j]);
            r.res_machine = mm;
            r.slot        = mach_slot[mm];
            r.begin_time  = start;
            r.end_time    = (sum > TIME_MAX) ? TIME_MAX : sum[TIME_W-1:0];
            scheduled_ops.push_back(r);
            job_ready[j]   = r.end_time;
            mach_ready[mm] = r.end_time;
            next_op[j]++;
            if (mach_slot[mm] != SLOT_MAX) mach_slot[mm]++;
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_result();
    res_t got;
    res_t want;
    got.res_job     = out_ch.res_job;
    got.res_op      = out_ch.res_op;
    got.res_machine = out_ch.res_machine;
    got.slot        = out_ch.slot;
    got.begin_time  = out_ch.begin_time;
    got.end_time    = out_ch.end_time;
    got.error       = out_ch.error;
    if (scheduled_ops.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("unexpected result: job=%0d op=%0d mach=%0d slot=%0d begin=%0d end=%0d err=%0b",
                 got.res_job, got.res_op, got.res_machine, got.slot, got.begin_time,
                 got.end_time, got.error);
    end else begin
      want = scheduled_ops.pop_front();
      if (got.res_job !== want.res_job || got.res_op !== want.res_op ||
          got.res_machine !== want.res_machine || got.slot !== want.slot ||
          got.begin_time !== want.begin_time || got.end_time !== want.end_time ||
          got.error !== want.error) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("mismatch exp: job=%0d op=%0d mach=%0d slot=%0d begin=%0d end=%0d err=%0b",
                   want.res_job, want.res_op, want.res_machine, want.slot, want.begin_time,
                   want.end_time, want.error);
          $display("mismatch got: job=%0d op=%0d mach=%0d slot=%0d begin=%0d end=%0d err=%0b",
                   got.res_job, got.res_op, got.res_machine, got.slot, got.begin_time,
                   got.end_time, got.error);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) check_result();
  end

  // one transaction on the input channel; valid stays high for a back-to-back follower
  task automatic send_item(func_t f, job_t j, op_t o, mach_t m, dur_t d);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid    <= 1'b1;
    in_ch.func     <= f;
    in_ch.job      <= j;
    in_ch.op_index <= o;
    in_ch.machine  <= m;
    in_ch.duration <= d;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    decode_transaction(f, j, o, m, d);
    if (f != FUNC_NOP) items_sent++;
  endtask

  // unused fields carry junk on purpose
  task automatic send_gene(job_t j);
    send_item(FUNC_GENE, j, op_t'($urandom), mach_t'($urandom), dur_t'($urandom));
  endtask

  task automatic send_clear();
    send_item(FUNC_CLEAR, job_t'($urandom), op_t'($urandom), mach_t'($urandom),
              dur_t'($urandom));
  endtask

  function automatic dur_t pick_duration();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3:    return dur_t'($urandom);
      default: return dur_t'($urandom_range(1, 20));
    endcase
  endfunction

  // a gene must never reach a routing entry that was not loaded
  function automatic bit gene_ok(job_t j);
    return next_op[j] >= N_OPS || route_loaded[int'(j) * N_OPS + next_op[j]];
  endfunction

  task automatic shuffle_ints(ref int q[$]);
    int t;
    int tmp;
    for (int k = q.size() - 1; k > 0; k--) begin
      t    = $urandom_range(k);
      tmp  = q[k];
      q[k] = q[t];
      q[t] = tmp;
    end
  endtask

  task automatic test_corner_items();
    send_item(FUNC_CLEAR, '1, '1, '1, '1);
    send_item(FUNC_LOAD, 6'd63, 5'd0, 5'd31, 16'hFFFF);
    send_item(FUNC_LOAD, 6'd0, 5'd0, 5'd0, 16'h0000);
    send_item(FUNC_LOAD, 6'd0, 5'd1, 5'd31, 16'd1);
    send_item(FUNC_LOAD, 6'd63, 5'd31, 5'd0, 16'h8000);
    send_item(FUNC_NOP, '1, '1, '1, '1);
    send_item(FUNC_NOP, '0, '0, '0, '0);
    send_gene(6'd63);
    send_gene(6'd0);
    send_gene(6'd0);          // waits on machine 31 behind job 63
    send_item(FUNC_LOAD, 6'd0, 5'd2, 5'd31, 16'h8000);
    send_gene(6'd0);
    send_item(FUNC_LOAD, 6'd0, 5'd0, 5'd17, 16'h7FFF);
    send_clear();
    send_gene(6'd0);          // restarts at op 0 with the overwritten entry
    send_gene(6'd63);
    send_gene(6'd0);
  endtask

  task automatic test_job_exhaustion();
    job_t j;
    j = job_t'($urandom);
    send_clear();
    for (int o = 0; o < N_OPS; o++)
      send_item(FUNC_LOAD, j, op_t'(o), mach_t'($urandom), pick_duration());
    for (int o = 0; o < N_OPS + 2; o++) send_gene(j);
    send_clear();
    send_gene(j);
    send_gene(j);
  endtask

  task automatic test_random_schedules(int target);
    int pool[N_JOBS];
    int chrom[$];
    int pairs[$];
    int n_jobs;
    int n_ops;
    int n_mach;
    int base;
    int stop;
    int t;
    int tmp;
    job_t jn;
    stop = items_sent + target;
    while (items_sent < stop) begin
      n_jobs = ($urandom_range(9) == 0) ? $urandom_range(1, N_JOBS) : $urandom_range(1, 6);
      n_mach = ($urandom_range(4) == 0) ? $urandom_range(1, N_MACH) : $urandom_range(1, 3);
      base   = $urandom_range(N_MACH - 1);
      for (int k = 0; k < N_JOBS; k++) pool[k] = k;
      for (int k = 0; k < n_jobs; k++) begin
        t       = $urandom_range(k, N_JOBS - 1);
        tmp     = pool[k];
        pool[k] = pool[t];
        pool[t] = tmp;
      end
      chrom.delete();
      pairs.delete();
      for (int k = 0; k < n_jobs; k++) begin
        n_ops = ($urandom_range(19) == 0) ? N_OPS : $urandom_range(1, 5);
        for (int o = 0; o < n_ops; o++) begin
          pairs.push_back(pool[k] * N_OPS + o);
          chrom.push_back(pool[k]);
        end
      end
      shuffle_ints(pairs);
      shuffle_ints(chrom);
      // occasionally keep ready times and counters from the previous set
      if ($urandom_range(5) != 0) send_clear();
      foreach (pairs[k])
        send_item(FUNC_LOAD, job_t'(pairs[k] / N_OPS), op_t'(pairs[k] % N_OPS),
                  mach_t'((base + $urandom_range(n_mach - 1)) % N_MACH), pick_duration());
      foreach (chrom[k]) begin
        if ($urandom_range(99) < 12) begin
          jn = job_t'($urandom);
          case ($urandom_range(9))
            0, 1, 2, 3:
              send_item(FUNC_NOP, jn, op_t'($urandom), mach_t'($urandom), dur_t'($urandom));
            4, 5, 6:
              send_item(FUNC_LOAD, jn, op_t'($urandom), mach_t'($urandom), pick_duration());
            7, 8:
              if (gene_ok(jn)) send_gene(jn);
            default: send_clear();
          endcase
        end
        if (gene_ok(job_t'(chrom[k]))) send_gene(job_t'(chrom[k]));
      end
    end
  endtask

  initial begin
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.func     <= FUNC_LOAD;
    in_ch.job      <= '0;
    in_ch.op_index <= '0;
    in_ch.machine  <= '0;
    in_ch.duration <= '0;
    mismatches = 0;
    items_sent = 0;
    clear_schedule();
    send_idle_pct = 36;
    recv_idle_pct = 77;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_corner_items();
    test_job_exhaustion();
    test_random_schedules(600);

    send_idle_pct = 77;
    recv_idle_pct = 36;
    test_random_schedules(600);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_job_exhaustion();
    test_random_schedules(550);

    in_ch.valid <= 1'b0;
    while (scheduled_ops.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/jssd_pkg.sv
hw/rtl/jssd_if.sv
hw/rtl/jssd_route_mem.sv
hw/rtl/jssd_vmem.sv
hw/rtl/job_shop_schedule_decoder_unit.sv
hw/rtl/jssd_chk.sv
tb/tb.sv
